@@ rtl/prms_pkg.sv @@
// Shared types and field widths for the pair residue mask sieve.
// No dependencies; used by prms_lookup and pair_residue_mask_sieve.
package prms_pkg;

  localparam int ROW_FIELD_W  = 10;
  localparam int SLOT_FIELD_W = 5;
  localparam int RES_FIELD_W  = 7;
  localparam int MASK_W       = 64;
  localparam int BIT_IDX_W    = 6;
  localparam int CNT_W        = 6;

  typedef enum logic [1:0] {
    FUNC_WR_RES  = 2'd0,
    FUNC_WR_MASK = 2'd1,
    FUNC_TEST    = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  // store write command, qualified by its enables
  typedef struct packed {
    logic                    res_we;
    logic                    mask_we;
    logic [ROW_FIELD_W-1:0]  row;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [RES_FIELD_W-1:0]  residue;
    logic [RES_FIELD_W-1:0]  mask_row;
    logic                    half;
    logic [MASK_W-1:0]       bits;
  } wr_req_t;

  // one per-prime lookup
  typedef struct packed {
    logic                    valid;
    logic [ROW_FIELD_W-1:0]  first_row;
    logic [ROW_FIELD_W-1:0]  second_row;
    logic [SLOT_FIELD_W-1:0] slot;
  } lk_req_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } lk_rsp_t;

endpackage

@@ rtl/prms_lookup.sv @@
// Residue and mask stores with the per-prime lookup pipeline.
// Depends on prms_pkg.
module prms_lookup #(
  parameter int MAX_ROWS      = 1024,
  parameter int MAX_PRIMES    = 32,
  parameter int RESIDUE_RANGE = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  prms_pkg::wr_req_t wr,
  input  prms_pkg::lk_req_t req,
  output prms_pkg::lk_rsp_t rsp
);
  import prms_pkg::*;

  localparam int ROWS_EFF  = (MAX_ROWS < (1 << ROW_FIELD_W)) ? MAX_ROWS : (1 << ROW_FIELD_W);
  localparam int ROW_W     = (ROWS_EFF > 1) ? $clog2(ROWS_EFF) : 1;
  localparam int SLOT_W    = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int RES_W     = $clog2(RESIDUE_RANGE);
  localparam int RES_DEPTH = ROWS_EFF * MAX_PRIMES;
  localparam int RA_W      = $clog2(RES_DEPTH);
  localparam int MSK_DEPTH = MAX_PRIMES * RESIDUE_RANGE * 2;
  localparam int MA_W      = $clog2(MSK_DEPTH);

  logic [RES_W-1:0]  res_mem  [RES_DEPTH];
  logic [MASK_W-1:0] mask_mem [MSK_DEPTH];

  logic [RA_W-1:0]   wr_res_addr;
  logic [RA_W-1:0]   rd_addr_a;
  logic [RA_W-1:0]   rd_addr_b;
  logic [MA_W-1:0]   wr_mask_base;
  logic [MA_W-1:0]   wr_mask_addr;
  logic [MA_W-1:0]   rd_mask_base;
  logic [MA_W-1:0]   rd_mask_addr;

  logic              v1;
  logic [SLOT_W-1:0] slot1;
  logic [RES_W-1:0]  res_a;
  logic [RES_W-1:0]  res_b;
  logic [RES_FIELD_W-1:0] b_ext;

  logic                 v2;
  logic [BIT_IDX_W-1:0] bidx2;
  logic [MASK_W-1:0]    word2;

  assign wr_res_addr  = RA_W'(wr.row[ROW_W-1:0]) * RA_W'(MAX_PRIMES)
                      + RA_W'(wr.slot[SLOT_W-1:0]);
  assign rd_addr_a    = RA_W'(req.first_row[ROW_W-1:0]) * RA_W'(MAX_PRIMES)
                      + RA_W'(req.slot[SLOT_W-1:0]);
  assign rd_addr_b    = RA_W'(req.second_row[ROW_W-1:0]) * RA_W'(MAX_PRIMES)
                      + RA_W'(req.slot[SLOT_W-1:0]);

  assign wr_mask_base = MA_W'(wr.slot[SLOT_W-1:0]) * MA_W'(RESIDUE_RANGE)
                      + MA_W'(wr.mask_row[RES_W-1:0]);
  assign wr_mask_addr = {wr_mask_base[MA_W-2:0], wr.half};

  assign b_ext        = RES_FIELD_W'(res_b);
  assign rd_mask_base = MA_W'(slot1) * MA_W'(RESIDUE_RANGE) + MA_W'(res_a);
  assign rd_mask_addr = {rd_mask_base[MA_W-2:0], b_ext[RES_FIELD_W-1]};

  always_ff @(posedge clk) begin
    if (wr.res_we) begin
      res_mem[wr_res_addr] <= wr.residue[RES_W-1:0];
    end
    res_a <= res_mem[rd_addr_a];
    res_b <= res_mem[rd_addr_b];
    slot1 <= req.slot[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr.mask_we) begin
      mask_mem[wr_mask_addr] <= wr.bits;
    end
    word2 <= mask_mem[rd_mask_addr];
    bidx2 <= b_ext[BIT_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
    end
  end

  assign rsp.valid = v2;
  assign rsp.ok    = word2[bidx2];

endmodule

@@ rtl/pair_residue_mask_sieve.sv @@
// Top level of the pair residue mask sieve: handshake, sequencer, result register.
// Depends on prms_pkg and prms_lookup.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_ready       func, rows, slot, residue, mask fields
//   out      source     out_valid / out_ready     is_test, pair_passes, tested rows
//   cfg      sink       cfg_write                 cfg_data (prime_count)
//
// n is prime_count capped at MAX_PRIMES. Write and no-op items, out-of-range tests
// and tests with n = 0 post their result directly from the idle state. Other tests
// issue n residue pair lookups, one per cycle, into a two-stage pipeline (residue
// memory read, then mask memory read).
// Reset clears control state and sets prime_count to 17; stores are not cleared.
// in_ready is low while a test runs or while an unaccepted result is held.
module pair_residue_mask_sieve #(
  parameter int MAX_ROWS      = 1024,
  parameter int MAX_PRIMES    = 32,
  parameter int RESIDUE_RANGE = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [prms_pkg::CNT_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          func,
  input  logic [prms_pkg::ROW_FIELD_W-1:0]    first_row,
  input  logic [prms_pkg::ROW_FIELD_W-1:0]    second_row,
  input  logic [prms_pkg::SLOT_FIELD_W-1:0]   prime_slot,
  input  logic [prms_pkg::RES_FIELD_W-1:0]    residue_value,
  input  logic [prms_pkg::RES_FIELD_W-1:0]    mask_row_residue,
  input  logic                                mask_half,
  input  logic [prms_pkg::MASK_W-1:0]         mask_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                is_test,
  output logic                                pair_passes,
  output logic [prms_pkg::ROW_FIELD_W-1:0]    tested_first,
  output logic [prms_pkg::ROW_FIELD_W-1:0]    tested_second
);
  import prms_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  prime_count;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  issue_cnt;
  logic [CNT_W-1:0]  chk_cnt;
  logic [CNT_W-1:0]  n_eff;
  logic              pass;

  logic              accept;
  func_t             fn;
  logic              first_ok;
  logic              second_ok;
  logic              slot_ok;
  logic              rval_ok;
  logic              mrow_ok;
  logic              last_chk;

  wr_req_t           wr;
  lk_req_t           req;
  lk_rsp_t           rsp;

  assign fn        = func_t'(func);
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  assign n_eff     = (prime_count > CNT_W'(MAX_PRIMES)) ? CNT_W'(MAX_PRIMES) : prime_count;
  assign first_ok  = {11'd0, first_row} < 21'(MAX_ROWS);
  assign second_ok = {11'd0, second_row} < 21'(MAX_ROWS);
  assign slot_ok   = {1'b0, prime_slot} < CNT_W'(MAX_PRIMES);
  assign rval_ok   = {1'b0, residue_value} < 8'(RESIDUE_RANGE);
  assign mrow_ok   = {1'b0, mask_row_residue} < 8'(RESIDUE_RANGE);

  assign wr.res_we   = accept && (fn == FUNC_WR_RES) && first_ok && slot_ok && rval_ok;
  assign wr.mask_we  = accept && (fn == FUNC_WR_MASK) && slot_ok && mrow_ok;
  assign wr.row      = first_row;
  assign wr.slot     = prime_slot;
  assign wr.residue  = residue_value;
  assign wr.mask_row = mask_row_residue;
  assign wr.half     = mask_half;
  assign wr.bits     = mask_bits;

  assign req.valid      = (state == ST_RUN) && (issue_cnt < limit);
  assign req.first_row  = tested_first;
  assign req.second_row = tested_second;
  assign req.slot       = issue_cnt[SLOT_FIELD_W-1:0];

  assign last_chk = (chk_cnt + CNT_W'(1)) == limit;

  prms_lookup #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_PRIMES    (MAX_PRIMES),
    .RESIDUE_RANGE (RESIDUE_RANGE)
  ) u_lookup (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= CNT_W'(17);
    end else if (cfg_write) begin
      prime_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      issue_cnt <= '0;
      chk_cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (fn == FUNC_TEST) begin
              tested_first  <= first_row;
              tested_second <= second_row;
              is_test       <= 1'b1;
              if (!first_ok || !second_ok || n_eff == '0) begin
                pair_passes <= first_ok && second_ok;
                out_valid   <= 1'b1;
              end else begin
                out_valid <= 1'b0;
                limit     <= n_eff;
                issue_cnt <= '0;
                chk_cnt   <= '0;
                pass      <= 1'b1;
                state     <= ST_RUN;
              end
            end else begin
              tested_first  <= '0;
              tested_second <= '0;
              is_test       <= 1'b0;
              pair_passes   <= 1'b0;
              out_valid     <= 1'b1;
            end
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_RUN: begin
          if (req.valid) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          if (rsp.valid) begin
            pass    <= pass && rsp.ok;
            chk_cnt <= chk_cnt + CNT_W'(1);
            if (last_chk) begin
              pair_passes <= pass && rsp.ok;
              out_valid   <= 1'b1;
              state       <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
